/* hdl/rld_pkg.sv */
package rld_pkg;

  // Default width of the element counter and the expected total
  localparam int unsigned COUNT_BITS_DEF = 24;

  localparam int unsigned CODE_W   = 8;
  localparam int unsigned ELEM_W   = 16;
  localparam int unsigned RUN_W    = 8;
  localparam int unsigned CNT_W    = 2;
  localparam int unsigned EXP_W    = 24;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned M_DATA_W = 40;
  localparam int unsigned M_USER_W = 2;

  localparam logic [7:0] REPEAT_BIT = 8'h80;
  localparam logic [7:0] LEN_MASK   = 8'h7F;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_MODE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_COUNT = 1'b1;

  // Work handed from the decoder to the result emitter
  typedef struct packed {
    logic              vld;   // a result is due for this byte
    logic [RUN_W-1:0]  cnt;   // elements to emit, 0 for status only
    logic [ELEM_W-1:0] val;   // element value
    logic              done;  // closes the stream
    logic              ok;    // stream status, valid with done
  } rld_job_t;

  // Emitter state seen by the top level for input flow control
  typedef struct packed {
    logic idle;
    logic finishing;
  } rld_emit_stat_t;

endpackage

/* hdl/rld_ctrl.sv */
module rld_ctrl #(
  parameter int unsigned CountBits = rld_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rld_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [rld_pkg::EXP_W-1:0]           cfg_wdata_i,
  input  logic                                accept_i,
  input  logic [rld_pkg::CODE_W-1:0]          code_byte_i,
  input  logic                                stream_end_i,
  output rld_pkg::rld_job_t                   job_o
);
  import rld_pkg::*;

  typedef enum logic [2:0] {
    PH_CTRL = 3'b001,
    PH_REP  = 3'b010,
    PH_LIT  = 3'b100
  } phase_e;

  logic                 mode_q;
  logic [EXP_W-1:0]     exp_q;
  phase_e               phase_q, phase_d;
  logic [RUN_W-1:0]     run_q, run_d;
  logic [CountBits-1:0] prod_q, prod_d;
  logic [7:0]           hold_q, hold_d;
  logic                 have_q, have_d;
  logic                 err_q, err_d;

  logic [31:0]          exp_ext;
  logic [CountBits-1:0] target;
  logic [RUN_W-1:0]     len;
  logic [CountBits:0]   sum;
  logic [ELEM_W-1:0]    val;
  rld_job_t             job;

  assign exp_ext = 32'(exp_q);
  assign target  = exp_ext[CountBits-1:0];
  assign len     = (code_byte_i & LEN_MASK) + RUN_W'(1);
  assign sum     = {1'b0, prod_q} + (CountBits+1)'(len);
  assign val     = mode_q ? {code_byte_i, hold_q} : {8'h00, code_byte_i};

  always_comb begin
    phase_d  = phase_q;
    run_d    = run_q;
    prod_d   = prod_q;
    hold_d   = hold_q;
    have_d   = have_q;
    err_d    = err_q;
    job      = '0;
    job.val  = val;
    if (!err_q) begin
      if (phase_q inside {PH_REP, PH_LIT}) begin
        if (mode_q && !have_q) begin
          hold_d = code_byte_i;
          have_d = 1'b1;
        end else begin
          have_d = 1'b0;
          if (phase_q == PH_REP) begin
            job.cnt = run_q;
            prod_d  = prod_q + CountBits'(run_q);
            run_d   = '0;
            phase_d = PH_CTRL;
          end else begin
            job.cnt = RUN_W'(1);
            prod_d  = prod_q + CountBits'(1);
            run_d   = run_q - RUN_W'(1);
            if (run_q == RUN_W'(1)) begin
              phase_d = PH_CTRL;
            end
          end
        end
      end else begin
        phase_d = PH_CTRL;
        if (prod_q >= target || sum > {1'b0, target}) begin
          err_d = 1'b1;
        end else begin
          run_d   = len;
          have_d  = 1'b0;
          phase_d = ((code_byte_i & REPEAT_BIT) != 8'h00) ? PH_REP : PH_LIT;
        end
      end
    end
    if (stream_end_i) begin
      job.done = 1'b1;
      job.ok   = !err_d && phase_d == PH_CTRL && prod_d == target;
      phase_d  = PH_CTRL;
      run_d    = '0;
      prod_d   = '0;
      hold_d   = '0;
      have_d   = 1'b0;
      err_d    = 1'b0;
    end
    job.vld = accept_i && (job.cnt != '0 || job.done);
  end

  assign job_o = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      exp_q   <= EXP_W'(1);
      phase_q <= PH_CTRL;
      run_q   <= '0;
      prod_q  <= '0;
      hold_q  <= '0;
      have_q  <= 1'b0;
      err_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ELEMENT_MODE:   mode_q <= cfg_wdata_i[0];
          CFG_EXPECTED_COUNT: exp_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (accept_i) begin
        phase_q <= phase_d;
        run_q   <= run_d;
        prod_q  <= prod_d;
        hold_q  <= hold_d;
        have_q  <= have_d;
        err_q   <= err_d;
      end
    end
  end

  // An error parks the decoder in the control phase
  a_err_ctrl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |-> phase_q == PH_CTRL)
    else $error("error flag set outside control phase");

  // A held low byte only exists inside a run
  a_hold_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_q |-> phase_q != PH_CTRL)
    else $error("low byte held outside a run");

  // A run in progress always has elements left
  a_run_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_REP || phase_q == PH_LIT) |-> run_q != '0)
    else $error("open run with zero length");

endmodule

/* hdl/rld_emit.sv */
module rld_emit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rld_pkg::rld_job_t               job_i,
  output rld_pkg::rld_emit_stat_t         stat_o,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [rld_pkg::M_DATA_W-1:0]    m_axis_tdata,
  output logic                            m_axis_tlast,
  output logic [rld_pkg::M_USER_W-1:0]    m_axis_tuser
);
  import rld_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

  state_e            st_q, st_d;
  logic [RUN_W-1:0]  rem_q, rem_d, rem_nxt;
  logic [ELEM_W-1:0] val_q, val_d;
  logic              done_q, done_d;
  logic              ok_q, ok_d;
  logic              mv_q, mv_d;
  logic [M_DATA_W-1:0] dat_q, dat_d;
  logic              lst_q, lst_d;
  logic [M_USER_W-1:0] usr_q, usr_d;

  logic              step;
  logic              last;
  logic [CNT_W-1:0]  take;

  assign step    = (st_q == ST_EMIT) && (!mv_q || m_axis_tready);
  assign take    = (rem_q >= RUN_W'(2)) ? CNT_W'(2) : CNT_W'(rem_q);
  assign rem_nxt = rem_q - RUN_W'(take);
  assign last    = (rem_nxt == '0);

  assign stat_o.idle      = (st_q == ST_IDLE);
  assign stat_o.finishing = step && last;

  always_comb begin
    st_d   = st_q;
    rem_d  = rem_q;
    val_d  = val_q;
    done_d = done_q;
    ok_d   = ok_q;
    mv_d   = mv_q && !m_axis_tready;
    dat_d  = dat_q;
    lst_d  = lst_q;
    usr_d  = usr_q;
    if (step) begin
      rem_d = rem_nxt;
      mv_d  = 1'b1;
      dat_d = {(M_DATA_W-2*ELEM_W-CNT_W)'(0), take,
               (take == CNT_W'(2)) ? val_q : ELEM_W'(0),
               (take != '0) ? val_q : ELEM_W'(0)};
      lst_d = last;
      usr_d = {last && ok_q, last && done_q};
      if (last) begin
        st_d = ST_IDLE;
      end
    end
    if (job_i.vld) begin
      st_d   = ST_EMIT;
      rem_d  = job_i.cnt;
      val_d  = job_i.val;
      done_d = job_i.done;
      ok_d   = job_i.ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      mv_q <= 1'b0;
    end else begin
      st_q <= st_d;
      mv_q <= mv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    val_q  <= val_d;
    done_q <= done_d;
    ok_q   <= ok_d;
    dat_q  <= dat_d;
    lst_q  <= lst_d;
    usr_q  <= usr_d;
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = dat_q;
  assign m_axis_tlast  = lst_q;
  assign m_axis_tuser  = usr_q;

  // New work only lands on a free or just-freed emitter
  a_job_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_i.vld |-> (st_q == ST_IDLE || (step && last)))
    else $error("job loaded while emitter busy");

  // A status-only word is the sole way to run with nothing left
  a_rem_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_EMIT && rem_q == '0) |-> done_q)
    else $error("empty job without stream close");

  // A step always leaves a word in the output register
  a_step_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> mv_q)
    else $error("emitted word lost");

  // Runs never exceed 128 elements
  a_rem_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_EMIT) |-> rem_q <= RUN_W'(128))
    else $error("run length out of range");

endmodule

/* hdl/run_length_decoder.sv */
// Channel  | Dir | Handshake                    | Payload
// s_axis   | in  | s_axis_tvalid/s_axis_tready  | tdata[7:0] code_byte, tlast stream_end
// m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata first/second_value, value_count;
//          |     |                              | tlast run_last; tuser stream_done, ok
// cfg      | in  | cfg_we_i (no back-pressure)  | cfg_idx_i, cfg_wdata_i
//
// Flow: a byte that yields neither elements nor a status word leaves the input
//   free. A byte that yields k elements holds the input while the emitter's down
//   counter hands out two elements a cycle, unless a held output word stalls it;
//   a repeat run of 128 elements holds the input until its final word is sent.
// Reset: rst_ni clears the decoder state, the emitter and the output valid;
//   element_mode resets to 0 and expected_count to 1.
// Stalls: a held output word stalls the emitter, and s_axis_tready drops
//   while the emitter still has words to send for the previous byte.
module run_length_decoder #(
  parameter int unsigned CountBits = rld_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port
  input  logic                            cfg_we_i,
  input  logic [rld_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rld_pkg::EXP_W-1:0]       cfg_wdata_i,
  // Encoded byte stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [rld_pkg::CODE_W-1:0]      s_axis_tdata,  // [7:0] code_byte
  input  logic                            s_axis_tlast,  // stream_end
  // Decoded results
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [15:0] first_value, [31:16] second_value, [33:32] value_count, [39:34] zero
  output logic [rld_pkg::M_DATA_W-1:0]    m_axis_tdata,
  output logic                            m_axis_tlast,  // run_last
  output logic [rld_pkg::M_USER_W-1:0]    m_axis_tuser   // [0] stream_done, [1] stream_ok
);
  import rld_pkg::*;

  rld_job_t       job;
  rld_emit_stat_t stat;
  logic           accept;

  // Take a byte while the emitter is free, or in the cycle it sends its
  // final word for the previous byte.
  assign s_axis_tready = stat.idle || stat.finishing;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Decode the byte: track phase, run length, produced count and errors,
  // and hand any resulting elements or stream status to the emitter.
  rld_ctrl #(
    .CountBits (CountBits)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .accept_i     (accept),
    .code_byte_i  (s_axis_tdata),
    .stream_end_i (s_axis_tlast),
    .job_o        (job)
  );

  // Drain the job two elements per word into the output register; the
  // final word carries run_last and, on stream close, the status.
  rld_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_i         (job),
    .stat_o        (stat),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import rld_pkg::*;

  // Generous bound: ~170 bytes x 64 words x random sink stalls, plus hold and settles
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned SETTLE_CYC  = 8;

  typedef enum logic [1:0] {
    PH_CTRL,
    PH_REP,
    PH_LIT
  } phase_e;

  // One encoded byte waiting to be offered
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              eos;
  } code_t;

  // One decoded output word
  typedef struct packed {
    logic [ELEM_W-1:0] val_a;
    logic [ELEM_W-1:0] val_b;
    logic [CNT_W-1:0]  n_vals;
    logic              run_last;
    logic              done;
    logic              ok;
  } word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_ELEMENT_MODE;
  logic [EXP_W-1:0]     cfg_wdata_i = '0;

  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [CODE_W-1:0]   s_axis_tdata = '0;   // [7:0] code_byte
  logic                s_axis_tlast = 1'b0; // stream_end

  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // [15:0] first_value, [31:16] second_value, [33:32] value_count
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic                m_axis_tlast;  // run_last
  logic [M_USER_W-1:0] m_axis_tuser;  // [0] stream_done, [1] stream_ok

  run_length_decoder DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  // Stimulus and expectation stores
  code_t code_q[$];
  word_t decoded_q[$];
  int unsigned err_cnt = 0;

  // Shadow of the decoder: registers and per-stream state
  logic             mode_r = 1'b0;
  logic [EXP_W-1:0] target_r = 24'd1;
  phase_e           ph_r = PH_CTRL;
  logic [RUN_W-1:0] run_r = '0;
  logic [EXP_W-1:0] produced_r = '0;
  logic [7:0]       low_r = '0;
  logic             have_low_r = 1'b0;
  logic             fault_r = 1'b0;

  // Idle controls, set by the sequence between streams
  bit src_idle_en = 1'b1;
  bit snk_idle_en = 1'b1;
  bit hold_req = 1'b0;

  function automatic int unsigned draw_gap(bit en);
    return en ? $urandom_range(0, 17) : 0;
  endfunction

  // Expand one accepted encoded byte into the words it must produce
  task automatic decode_byte(input logic [CODE_W-1:0] b, input logic eos);
    word_t             outs[64];
    int                n;
    int                left;
    logic [ELEM_W-1:0] v;
    logic [RUN_W-1:0]  cnt;
    logic [EXP_W:0]    reach;
    logic              ok;
    n = 0;
    if (!fault_r) begin
      if (ph_r == PH_REP || ph_r == PH_LIT) begin
        if (mode_r && !have_low_r) begin
          // hold the low byte of a word; nothing leaves yet
          low_r = b;
          have_low_r = 1'b1;
        end else begin
          v = mode_r ? {b, low_r} : {8'h00, b};
          have_low_r = 1'b0;
          if (ph_r == PH_REP) begin
            left = run_r;
            produced_r = produced_r + EXP_W'(left);
            // pack the repeat two elements per word
            while (left > 0) begin
              outs[n] = '0;
              outs[n].val_a = v;
              outs[n].val_b = (left >= 2) ? v : '0;
              outs[n].n_vals = (left >= 2) ? 2'd2 : 2'd1;
              left -= (left >= 2) ? 2 : 1;
              n++;
            end
            run_r = '0;
            ph_r = PH_CTRL;
          end else begin
            outs[0] = '0;
            outs[0].val_a = v;
            outs[0].n_vals = 2'd1;
            n = 1;
            produced_r = produced_r + 1'b1;
            run_r = run_r - 1'b1;
            if (run_r == 0) ph_r = PH_CTRL;
          end
        end
      end else begin
        cnt = RUN_W'(b & LEN_MASK) + 1'b1;
        reach = {1'b0, produced_r} + (EXP_W + 1)'(cnt);
        ph_r = PH_CTRL;
        // overrun or excess input: flag and skip the run
        if (produced_r >= target_r || reach > {1'b0, target_r}) begin
          fault_r = 1'b1;
        end else begin
          run_r = cnt;
          have_low_r = 1'b0;
          ph_r = (b & REPEAT_BIT) != 0 ? PH_REP : PH_LIT;
        end
      end
    end
    if (eos) begin
      ok = !fault_r && ph_r == PH_CTRL && produced_r == target_r;
      if (n == 0) begin
        outs[0] = '0;  // status-only word
        n = 1;
      end
      outs[n-1].done = 1'b1;
      outs[n-1].ok = ok;
      ph_r = PH_CTRL;
      run_r = '0;
      produced_r = '0;
      low_r = '0;
      have_low_r = 1'b0;
      fault_r = 1'b0;
    end
    if (n > 0) outs[n-1].run_last = 1'b1;
    for (int i = 0; i < n; i++) decoded_q.push_back(outs[i]);
  endtask

  // Driver: offer queued bytes, hold each until taken, then wait its gap
  int unsigned tx_wait = 0;
  bit          tx_offer;
  code_t       tx_cur;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) decode_byte(s_axis_tdata, s_axis_tlast);
      tx_offer = s_axis_tvalid && !s_axis_tready;
      if (!tx_offer) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (code_q.size() > 0) begin
          tx_cur = code_q.pop_front();
          s_axis_tdata <= tx_cur.code;
          s_axis_tlast <= tx_cur.eos;
          tx_offer = 1'b1;
          tx_wait = draw_gap(src_idle_en);
        end
      end
      // single assignment per edge keeps a back-to-back valid high
      s_axis_tvalid <= tx_offer;
    end
  end

  // Monitor: check each taken word, then stall the sink for a drawn count
  int unsigned rx_wait = 0;
  word_t       got;
  word_t       want;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.val_a = m_axis_tdata[15:0];
        got.val_b = m_axis_tdata[31:16];
        got.n_vals = m_axis_tdata[33:32];
        got.run_last = m_axis_tlast;
        got.done = m_axis_tuser[0];
        got.ok = m_axis_tuser[1];
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected word first=%h second=%h count=%0d last=%b done=%b ok=%b",
                   $time, got.val_a, got.val_b, got.n_vals, got.run_last, got.done, got.ok);
          err_cnt++;
        end else begin
          want = decoded_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch, expected first=%h second=%h count=%0d last=%b done=%b ok=%b",
                     $time, want.val_a, want.val_b, want.n_vals, want.run_last, want.done,
                     want.ok);
            $display("%0t:             actual first=%h second=%h count=%0d last=%b done=%b ok=%b",
                     $time, got.val_a, got.val_b, got.n_vals, got.run_last, got.done, got.ok);
            err_cnt++;
          end
        end
      end
      if (hold_req) begin
        // long back-pressure so the decoder fills and stalls its input
        rx_wait = LONG_HOLD;
        hold_req <= 1'b0;
      end else if (m_axis_tvalid && m_axis_tready) begin
        rx_wait = draw_gap(snk_idle_en);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      m_axis_tready <= (rx_wait == 0);
    end
  end

  // Watchdog
  int unsigned cycle_cnt = 0;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic put(input logic [7:0] b, input logic eos);
    code_q.push_back('{code: b, eos: eos});
  endtask

  // Wait until nothing is queued, offered or expected, then let the block drain
  task automatic settle();
    do @(negedge clk_i);
    while (code_q.size() != 0 || s_axis_tvalid || decoded_q.size() != 0);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [EXP_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    if (idx == CFG_ELEMENT_MODE) mode_r = val[0];
    else target_r = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Build one encoded stream: mostly well formed, some damaged, some noise
  task automatic random_stream(input bit long_run, output int n_items);
    logic [7:0]       seq[$];
    int               runs;
    int               len;
    int               total;
    int               kind;
    int               r;
    int               e;
    logic             wm;
    logic             rep;
    logic [15:0]      v;
    logic [EXP_W-1:0] tgt;
    seq = {};
    wm = 1'($urandom_range(0, 1));
    kind = long_run ? 0 : $urandom_range(0, 9);
    total = 0;
    runs = $urandom_range(1, 4);
    for (r = 0; r < runs; r++) begin
      rep = (long_run && r == 0) ? 1'b1 : 1'($urandom_range(0, 1));
      if (long_run && r == 0) len = 128;
      else if (rep) len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 128)
                                                      : $urandom_range(1, 6);
      else len = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 16) : $urandom_range(1, 4);
      seq.push_back({rep, 7'(len - 1)});
      total += len;
      for (e = 0; e < (rep ? 1 : len); e++) begin
        v = 16'($urandom);
        seq.push_back(v[7:0]);
        if (wm) seq.push_back(v[15:8]);
      end
    end
    tgt = EXP_W'(total);
    n_items = seq.size();
    if (kind == 6 || kind == 7) begin
      // wrong target: short, long, or the largest one
      if ($urandom_range(0, 3) == 0) tgt = '1;
      else tgt = $urandom_range(0, 1) ? tgt + 1'b1 : tgt - 1'b1;
    end else if (kind == 8) begin
      // truncate the stream or tack excess input on the end
      if ($urandom_range(0, 1) && seq.size() > 1) void'(seq.pop_back());
      else seq.push_back(8'($urandom));
      n_items = seq.size();
    end else if (kind == 9) begin
      seq = {};
      repeat ($urandom_range(1, 6)) seq.push_back(8'($urandom));
      tgt = EXP_W'($urandom_range(1, 8));
      n_items = seq.size();
    end
    settle();
    src_idle_en = long_run ? 1'b0 : ($urandom_range(0, 2) != 0);
    snk_idle_en = $urandom_range(0, 2) != 0;
    cfg_write(CFG_ELEMENT_MODE, EXP_W'(wm));
    cfg_write(CFG_EXPECTED_COUNT, tgt);
    if (long_run) hold_req = 1'b1;
    foreach (seq[i]) put(seq[i], i == seq.size() - 1);
  endtask

  initial begin
    int n_rand;
    int n_items;
    int idx;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset defaults: byte mode, one element
    put(8'h00, 1'b0);
    put(8'hFF, 1'b1);

    // Longest repeat: 128 bytes in 64 words
    settle();
    cfg_write(CFG_EXPECTED_COUNT, 24'd128);
    put(8'hFF, 1'b0);
    put(8'h00, 1'b1);

    // Word mode: literal word, then a repeat of one word
    settle();
    cfg_write(CFG_ELEMENT_MODE, 24'd1);
    cfg_write(CFG_EXPECTED_COUNT, 24'd2);
    put(8'h00, 1'b0);
    put(8'h34, 1'b0);
    put(8'h12, 1'b0);
    put(8'h80, 1'b0);
    put(8'hFF, 1'b0);
    put(8'hFF, 1'b1);

    // Overrun: repeat of 4 against a target of 3; drop bytes until the end
    settle();
    cfg_write(CFG_ELEMENT_MODE, 24'd0);
    cfg_write(CFG_EXPECTED_COUNT, 24'd3);
    put(8'h83, 1'b0);
    put(8'h55, 1'b0);
    put(8'h00, 1'b1);

    // Excess input: a control byte after the target is reached
    settle();
    cfg_write(CFG_EXPECTED_COUNT, 24'd1);
    put(8'h80, 1'b0);
    put(8'h7F, 1'b0);
    put(8'h00, 1'b0);
    put(8'h11, 1'b1);

    // Truncation: stream ends on the control byte
    settle();
    cfg_write(CFG_EXPECTED_COUNT, 24'd4);
    put(8'h03, 1'b1);

    // Truncation: stream ends after the low byte of a word
    settle();
    cfg_write(CFG_ELEMENT_MODE, 24'd1);
    cfg_write(CFG_EXPECTED_COUNT, 24'd2);
    put(8'h81, 1'b0);
    put(8'h10, 1'b1);

    // Mode flip inside a literal: the held low byte is dropped
    settle();
    put(8'h01, 1'b0);
    put(8'hAA, 1'b0);
    settle();
    cfg_write(CFG_ELEMENT_MODE, 24'd0);
    put(8'hBB, 1'b0);
    put(8'hCC, 1'b1);

    // Zero target: any byte is excess
    settle();
    cfg_write(CFG_EXPECTED_COUNT, 24'd0);
    put(8'h00, 1'b1);

    // Random streams; the fourth one holds the sink off during a long repeat
    n_rand = 0;
    idx = 0;
    while (n_rand < 130) begin
      random_stream(idx == 3, n_items);
      n_rand += n_items;
      idx++;
    end

    settle();
    repeat (24) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
